FILE: sv/gf2_polynomial_alu_assert.svh
// Assertion macros used by the polynomial ALU top module.
`ifndef GF2_POLYNOMIAL_ALU_ASSERT_SVH
`define GF2_POLYNOMIAL_ALU_ASSERT_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define GPA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpa assertion failed");
// Antecedent implies consequent in the next cycle.
`define GPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpa assertion failed");
`else
`define GPA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/gpa_pkg.sv
// Types and constants of the GF(2) polynomial ALU.
package gpa_pkg;

  // Coefficient positions of an operand that count
  localparam int OPERAND_BITS = 32;
  localparam int OPD_W        = 32;
  localparam int RES_W        = 64;
  localparam int SH_W         = 6;
  localparam int REQ_W        = 3;
  localparam int IDX_W        = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 72;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_SHL = 3'd2,
    OP_REM = 3'd3,
    OP_EQ  = 3'd4,
    OP_LT  = 3'd5
  } op_t;

  // Step commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic shl_step;
    logic norm_step;
    logic red_step;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic mul_end;
    logic cnt_one;
    logic cnt_zero;
    logic top_bit;
  } stat_t;

endpackage

FILE: sv/gpa_datapath.sv
// Operand registers and the shared shift/XOR unit of the polynomial ALU.
module gpa_datapath import gpa_pkg::*; (
  input  logic              clk,
  input  ctrl_t             ctrl,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [OPD_W-1:0]  operand_a,
  input  logic [OPD_W-1:0]  operand_b,
  input  logic [SH_W-1:0]   shift_amount,
  output stat_t             stat,
  output logic [RES_W-1:0]  result_poly,
  output logic              compare_flag,
  output logic              error
);

  logic [REQ_W-1:0]        op;
  logic [RES_W-1:0]        acc;
  logic [RES_W-1:0]        opnd;
  logic [OPERAND_BITS-1:0] ctl;
  logic [SH_W-1:0]         cnt;
  logic [IDX_W-1:0]        idx;
  logic [RES_W-1:0]        a_trim;
  logic [RES_W-1:0]        b_trim;
  logic [RES_W-1:0]        acc_xor;

  assign a_trim  = RES_W'(operand_a[OPERAND_BITS-1:0]);
  assign b_trim  = RES_W'(operand_b[OPERAND_BITS-1:0]);
  // Shared unit: one conditional XOR of the shifted operand into the accumulator
  assign acc_xor = acc ^ opnd;

  // Load and iterate
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op   <= req_type;
      acc  <= (req_type == OP_MUL) ? '0 : a_trim;
      opnd <= (req_type == OP_MUL || req_type == OP_SHL) ? a_trim : b_trim;
      ctl  <= operand_b[OPERAND_BITS-1:0];
      cnt  <= (req_type == OP_SHL) ? shift_amount : '0;
      idx  <= IDX_W'(OPERAND_BITS - 1);
    end else if (ctrl.mul_step) begin
      if (ctl[0]) begin
        acc <= acc_xor;
      end
      opnd <= opnd << 1;
      ctl  <= ctl >> 1;
      cnt  <= cnt + 1'b1;
    end else if (ctrl.shl_step) begin
      opnd <= opnd << 1;
      cnt  <= cnt - 1'b1;
    end else if (ctrl.norm_step) begin
      // align divisor top coefficient with the top operand position
      opnd <= opnd << 1;
      cnt  <= cnt + 1'b1;
    end else if (ctrl.red_step) begin
      if (acc[idx]) begin
        acc <= acc_xor;
      end
      opnd <= opnd >> 1;
      cnt  <= cnt - 1'b1;
      idx  <= idx - 1'b1;
    end
  end

  // Status
  assign stat.mul_end  = (cnt == SH_W'(OPERAND_BITS - 1));
  assign stat.cnt_one  = (cnt == SH_W'(1));
  assign stat.cnt_zero = (cnt == '0);
  assign stat.top_bit  = opnd[OPERAND_BITS-1];

  // Result selection
  always_comb begin
    result_poly  = '0;
    compare_flag = 1'b0;
    error        = 1'b0;
    case (op)
      OP_ADD: result_poly = acc_xor;
      OP_MUL: result_poly = acc;
      OP_SHL: result_poly = opnd;
      OP_REM: begin
        if (ctl == '0) begin
          error = 1'b1;
        end else begin
          result_poly = acc;
        end
      end
      OP_EQ:  compare_flag = (acc[OPERAND_BITS-1:0] == opnd[OPERAND_BITS-1:0]);
      OP_LT:  compare_flag = (acc[OPERAND_BITS-1:0] < opnd[OPERAND_BITS-1:0]);
      default: ;
    endcase
  end

endmodule

FILE: sv/gf2_polynomial_alu.sv
// Add, equal, less-than and remainder by a zero divisor go straight to the result; multiply
// steps through the bits of operand b; shift steps the operand left one position at a time
// (no steps when n is 0); remainder normalizes, then does one reduction per position.
// One request at a time: the next input transfer can come the cycle after the result is
// registered, and the result waits in the sequencer while the output is stalled.
// Synchronous active-high reset clears the sequencer and the output valid.
module gf2_polynomial_alu import gpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] operand_a, [63:32] operand_b, [69:64] shift_amount, [71:70] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [REQ_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] result_poly, [64] compare_flag, [65] error, [71:66] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

`include "gf2_polynomial_alu_assert.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_SHL  = 6'b000100,
    S_NORM = 6'b001000,
    S_RED  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  ctrl_t              ctrl;
  stat_t              stat;
  logic [OPD_W-1:0]   operand_a;
  logic [OPD_W-1:0]   operand_b;
  logic [SH_W-1:0]    shift_amount;
  logic [RES_W-1:0]   dp_poly;
  logic               dp_flag;
  logic               dp_err;
  logic [RES_W-1:0]   out_poly;
  logic               out_flag;
  logic               out_err;
  logic               in_xfer;
  logic               out_load;

  assign operand_a    = s_axis_tdata[OPD_W-1:0];
  assign operand_b    = s_axis_tdata[2*OPD_W-1:OPD_W];
  assign shift_amount = s_axis_tdata[2*OPD_W+SH_W-1:2*OPD_W];

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer
  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ctrl.load = 1'b1;
          case (s_axis_tuser)
            OP_MUL: state_next = S_MUL;
            OP_SHL: state_next = (shift_amount == '0) ? S_FIN : S_SHL;
            OP_REM: state_next = (operand_b[OPERAND_BITS-1:0] == '0) ? S_FIN : S_NORM;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_MUL: begin
        ctrl.mul_step = 1'b1;
        if (stat.mul_end) begin
          state_next = S_FIN;
        end
      end
      S_SHL: begin
        ctrl.shl_step = 1'b1;
        if (stat.cnt_one) begin
          state_next = S_FIN;
        end
      end
      S_NORM: begin
        if (stat.top_bit) begin
          state_next = S_RED;
        end else begin
          ctrl.norm_step = 1'b1;
        end
      end
      S_RED: begin
        ctrl.red_step = 1'b1;
        if (stat.cnt_zero) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  gpa_datapath u_datapath (
    .clk          (clk),
    .ctrl         (ctrl),
    .req_type     (s_axis_tuser),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .shift_amount (shift_amount),
    .stat         (stat),
    .result_poly  (dp_poly),
    .compare_flag (dp_flag),
    .error        (dp_err)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_poly <= dp_poly;
      out_flag <= dp_flag;
      out_err  <= dp_err;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W-RES_W-2)'(0), out_err, out_flag, out_poly};

  // Checks
  `GPA_ASSERT_SAME(a_err_zero, clk, rst, m_axis_tvalid && out_err, out_poly == '0 && !out_flag)
  `GPA_ASSERT_SAME(a_flag_zero, clk, rst, m_axis_tvalid && out_flag, out_poly == '0 && !out_err)
  `GPA_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_xfer, !s_axis_tready)
  `GPA_ASSERT_NEXT(a_out_from_fin, clk, rst, out_load, m_axis_tvalid && s_axis_tready)

endmodule
